@@ rtl/arb_pkg.sv @@
// Shared types and constants for the audio ring buffer with newest-sample reads.
package arb_pkg;

   // Store geometry. DEPTH must be a power of two so the pointers wrap by overflow.
   localparam int DEPTH    = 4096;
   localparam int AW       = $clog2(DEPTH);
   localparam int CW       = AW + 1;
   localparam int MAX_READ = 64;
   localparam int NW       = $clog2(MAX_READ + 1);

   // Operation codes carried in the request.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef struct packed {
      logic               operation;
      logic signed [15:0] sample_in;
      logic               block_start;
      logic [6:0]         max_count;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               sample_valid;
      logic               last_of_read;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic write_en;
      logic load_read;
      logic rd_issue;
      logic emit_empty;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic want_zero;
      logic fill_zero;
      logic last_issue;
      logic out_free;
   } sts_type;

endpackage

@@ rtl/arb_dpath.sv @@
// Datapath: sample memory, pointers, fill count, burst counter and result register.
module arb_dpath (
   input  logic             clock,
   input  logic             reset,
   input  arb_pkg::req_type req_data,
   input  arb_pkg::cmd_type cmd,
   output arb_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output arb_pkg::rsp_type rsp_data
);

   logic signed [15:0] mem [arb_pkg::DEPTH];

   logic [arb_pkg::AW-1:0] wp_ff, wp_in;
   logic [arb_pkg::AW-1:0] rp_ff, rp_in;
   logic [arb_pkg::CW-1:0] fill_ff, fill_in;
   logic [arb_pkg::AW-1:0] addr_ff, addr_in;
   logic [arb_pkg::NW-1:0] remain_ff, remain_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]     rdata_ff;
   logic                   sv_ff;
   logic                   last_ff;

   logic                   ovf;
   logic [arb_pkg::AW-1:0] wp_base;
   logic [arb_pkg::AW-1:0] rp_base;
   logic [arb_pkg::CW-1:0] fill_base;
   logic [arb_pkg::NW-1:0] want_sat;
   logic [arb_pkg::NW-1:0] count;

   always_comb begin
      // Overflow on a block start empties the store before the sample goes in.
      ovf       = req_data.block_start && (fill_ff >= arb_pkg::CW'(arb_pkg::DEPTH - 1));
      wp_base   = ovf ? '0 : wp_ff;
      rp_base   = ovf ? '0 : rp_ff;
      fill_base = ovf ? '0 : fill_ff;

      want_sat = (req_data.max_count > 7'(arb_pkg::MAX_READ)) ?
                 arb_pkg::NW'(arb_pkg::MAX_READ) : arb_pkg::NW'(req_data.max_count);
      count    = (fill_ff < arb_pkg::CW'(want_sat)) ? arb_pkg::NW'(fill_ff) : want_sat;

      wp_in        = wp_ff;
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      addr_in      = addr_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.write_en) begin
         wp_in = wp_base + 1'b1;
         if (fill_base == arb_pkg::CW'(arb_pkg::DEPTH)) begin
            rp_in = rp_base + 1'b1;
         end else begin
            rp_in   = rp_base;
            fill_in = fill_base + 1'b1;
         end
      end

      if (cmd.load_read) begin
         // The newest count samples end just below the write pointer.
         addr_in   = wp_ff - arb_pkg::AW'(count);
         remain_in = count;
         rp_in     = wp_ff;
         fill_in   = '0;
      end

      if (cmd.rd_issue) begin
         addr_in   = addr_ff + 1'b1;
         remain_in = remain_ff - 1'b1;
      end

      if (cmd.rd_issue || cmd.emit_empty) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (cmd.rd_issue || cmd.emit_empty) begin
         sv_ff   <= cmd.rd_issue;
         last_ff <= cmd.emit_empty || (remain_ff == arb_pkg::NW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         mem[wp_base] <= req_data.sample_in;
      end
      if (cmd.rd_issue) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   always_comb begin
      sts.want_zero  = (req_data.max_count == '0);
      sts.fill_zero  = (fill_ff == '0);
      sts.last_issue = (remain_ff == arb_pkg::NW'(1));
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.sample_out   = sv_ff ? rdata_ff : '0;
   assign rsp_data.sample_valid = sv_ff;
   assign rsp_data.last_of_read = last_ff;

endmodule

@@ rtl/arb_ctrl.sv @@
// Controller: accepts requests and sequences the read bursts.
module arb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_operation,
   output logic             req_stall,
   input  arb_pkg::sts_type sts,
   output arb_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BURST,
      ST_EMPTY
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && !req_stall;

      cmd.write_en   = accept && (req_operation == arb_pkg::OP_WRITE);
      cmd.load_read  = accept && (req_operation == arb_pkg::OP_READ) &&
                       !sts.want_zero && !sts.fill_zero;
      cmd.rd_issue   = (state_ff == ST_BURST) && sts.out_free;
      cmd.emit_empty = (state_ff == ST_EMPTY) && sts.out_free;

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == arb_pkg::OP_READ) && !sts.want_zero) begin
               state_in = sts.fill_zero ? ST_EMPTY : ST_BURST;
            end
         end
         ST_BURST: begin
            if (cmd.rd_issue && sts.last_issue) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (cmd.emit_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/audio_ring_buffer_latest_read.sv @@
// Top level of the audio ring buffer that returns the newest samples on each read.
//
// This block keeps a circular store of 4096 signed 16-bit audio samples in a
// single-port-write, registered-read memory. A write transfer stores one
// sample, and the next request can be taken in the following cycle. If a
// write marked as the start of a block arrives while 4095 or more samples are
// waiting, the store is emptied first and the sample becomes the only one held.
// A write into a full store without a block start overwrites the oldest sample.
// A read transfer asks for up to max_count samples (values above 64 count as 64)
// and returns the newest of the waiting samples, oldest of them first, one
// result transfer per cycle while the result side does not stall, with
// last_of_read set on the final one; afterwards nothing remains waiting. A
// read of an empty store returns one result with sample_valid low and
// sample_out zero, and a read with max_count zero returns nothing. A read
// holds off further requests until its burst has walked the memory read port,
// one address per cycle while results are not stalled, or until an empty read
// has issued its result. The result register lets the next request be accepted
// while the final result of a read still waits to be taken. There is no clearing
// pass after reset: the block is ready in the first cycle after reset falls.
module audio_ring_buffer_latest_read (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  arb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output arb_pkg::rsp_type rsp_data
);

   arb_pkg::cmd_type cmd;
   arb_pkg::sts_type sts;

   // The controller decides when a request is taken and when each memory read
   // of a burst may be issued.
   arb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   // The datapath owns the memory, the pointers and the result register.
   arb_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A memory read is only issued when the result register can take its data.
   a_issue_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_issue || cmd.emit_empty) |-> sts.out_free)
      else $error("result produced while the result register is held");

   // A burst read and an empty-read result never happen in the same cycle.
   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_issue && cmd.emit_empty))
      else $error("two result sources active together");

   // An empty-read result always closes its read.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.sample_valid) |-> rsp_data.last_of_read)
      else $error("invalid result without last flag");

   // An accepted read that wants samples holds off the next request.
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.operation == arb_pkg::OP_READ) &&
       !sts.want_zero) |=> req_stall)
      else $error("request taken during a read burst");

   // A write leaves the block ready for the next request.
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.write_en |=> !req_stall)
      else $error("write stalled the request channel");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the audio ring buffer that returns the newest samples.
`timescale 1ns / 100ps

module tb_top;

   // One request waiting to be driven, with the pacing that goes with it.
   // A drain request is held back until every predicted sample has been taken.
   // A steady request turns random gaps off on both channels.
   typedef struct {
      arb_pkg::req_type item;
      bit               drain_first;
      bit               steady;
   } request_slot_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   arb_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   arb_pkg::rsp_type rsp_data;

   // The sender sets this when it presents a steady request. The receiver reads it
   // to stop stalling, so the no-gap stretch covers both sides at once.
   logic    steady_now = 1'b0;

   request_slot_type requests_waiting[$];
   arb_pkg::rsp_type samples_due[$];
   int               error_count = 0;

   // Flags used only while the stimulus list is built.
   bit          steady_phase = 1'b0;
   bit          drain_next = 1'b0;

   // Shadow copy of the ring. Pointers are exactly AW bits wide, so adding to them
   // wraps modulo DEPTH the same way the hardware does.
   logic [15:0]            ring_copy [0:arb_pkg::DEPTH-1];
   logic [arb_pkg::AW-1:0] wr_ptr = '0;
   logic [arb_pkg::AW-1:0] rd_ptr = '0;
   logic [arb_pkg::CW-1:0] fill_level = '0;

   audio_ring_buffer_latest_read dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Reset is held at start-up and never raised again.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Applies one accepted request to the shadow ring and queues the samples that
   // the block must return for it.
   task automatic ring_apply(input arb_pkg::req_type r);
      int               held;
      int               wanted;
      int               count;
      arb_pkg::rsp_type res;
      held = fill_level;
      if (r.operation == arb_pkg::OP_WRITE) begin
         // A block start on a nearly full ring throws away everything held.
         if (r.block_start && held >= arb_pkg::DEPTH - 1) begin
            fill_level = '0;
            wr_ptr = '0;
            rd_ptr = '0;
         end
         ring_copy[wr_ptr] = r.sample_in;
         wr_ptr = wr_ptr + 1'b1;
         // A write into a full ring pushes the oldest sample out.
         if (fill_level >= arb_pkg::DEPTH)
            rd_ptr = rd_ptr + 1'b1;
         else
            fill_level = fill_level + 1'b1;
      end else if (r.max_count != 0) begin
         wanted = (r.max_count > arb_pkg::MAX_READ) ? arb_pkg::MAX_READ : r.max_count;
         if (held == 0) begin
            res.sample_out = '0;
            res.sample_valid = 1'b0;
            res.last_of_read = 1'b1;
            samples_due.push_back(res);
         end else begin
            count = (wanted < held) ? wanted : held;
            // Skip the surplus so that only the newest samples come back.
            rd_ptr = rd_ptr + arb_pkg::AW'(held - count);
            for (int k = 0; k < count; k++) begin
               res.sample_out = ring_copy[rd_ptr];
               res.sample_valid = 1'b1;
               res.last_of_read = (k + 1 == count);
               samples_due.push_back(res);
               rd_ptr = rd_ptr + 1'b1;
            end
            fill_level = '0;
         end
      end
   endtask

   task automatic queue_request(input arb_pkg::req_type r);
      request_slot_type slot;
      slot.item = r;
      slot.drain_first = drain_next;
      slot.steady = steady_phase;
      drain_next = 1'b0;
      requests_waiting.push_back(slot);
   endtask

   // A write carries a random max_count, which the block must ignore.
   task automatic queue_write(input logic [15:0] sample, input bit start);
      arb_pkg::req_type r;
      r.operation = arb_pkg::OP_WRITE;
      r.sample_in = sample;
      r.block_start = start;
      r.max_count = 7'($urandom_range(0, 127));
      queue_request(r);
   endtask

   // A read carries random sample and block start bits, which are ignored too.
   task automatic queue_read(input int count);
      arb_pkg::req_type r;
      r.operation = arb_pkg::OP_READ;
      r.sample_in = 16'($urandom);
      r.block_start = 1'($urandom_range(0, 1));
      r.max_count = 7'(count);
      queue_request(r);
   endtask

   // Writes n random samples. Block start is random only while the ring is far
   // from the drop threshold, so it must have no effect there.
   task automatic queue_fill(input int n);
      for (int k = 0; k < n; k++)
         queue_write(16'($urandom), (k < n - 8) ? bit'($urandom_range(0, 1)) : 1'b0);
   endtask

   // Sender. The next request is presented only when the current one has been
   // transferred or nothing is on the bus, so a stalled payload never moves.
   always @(posedge clock) begin : sender
      bit take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            ring_apply(req_data);
         if (!req_valid || !req_stall) begin
            take = requests_waiting.size() > 0;
            if (take && requests_waiting[0].drain_first && samples_due.size() != 0)
               take = 1'b0;
            if (take && !requests_waiting[0].steady && $urandom_range(0, 99) < 24)
               take = 1'b0;
            if (take) begin
               req_valid <= 1'b1;
               req_data <= requests_waiting[0].item;
               steady_now <= requests_waiting[0].steady;
               void'(requests_waiting.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Each transferred result is checked against the oldest prediction,
   // one field at a time, and the stall is redrawn every cycle.
   always @(posedge clock) begin : receiver
      arb_pkg::rsp_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (samples_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %p", $time, rsp_data);
               error_count++;
            end else begin
               due = samples_due.pop_front();
               if (rsp_data.sample_out !== due.sample_out) begin
                  $display("%0t: sample_out expected %0d, got %0d", $time,
                           due.sample_out, rsp_data.sample_out);
                  error_count++;
               end
               if (rsp_data.sample_valid !== due.sample_valid) begin
                  $display("%0t: sample_valid expected %0b, got %0b", $time,
                           due.sample_valid, rsp_data.sample_valid);
                  error_count++;
               end
               if (rsp_data.last_of_read !== due.last_of_read) begin
                  $display("%0t: last_of_read expected %0b, got %0b", $time,
                           due.last_of_read, rsp_data.last_of_read);
                  error_count++;
               end
            end
         end
         rsp_stall <= steady_now ? 1'b0 : ($urandom_range(0, 99) < 24);
      end
   end

   // Stimulus, then the end of the run.
   initial begin
      int made;
      int len;
      int pick;

      // Directed part: empty reads, a zero count, extreme samples, dropping of the
      // surplus, saturation of large counts and short reads.
      queue_read(5);
      queue_read(0);
      queue_write(16'sh7fff, 1'b1);
      queue_write(16'sh8000, 1'b0);
      queue_write(16'sh0000, 1'b1);
      queue_write(16'shffff, 1'b0);
      queue_write(16'sh0001, 1'b0);
      queue_read(0);
      queue_read(2);
      queue_write(16'sh5555, 1'b0);
      queue_write(16'shaaaa, 1'b1);
      queue_write(16'sh1234, 1'b0);
      queue_read(127);
      queue_read(64);
      queue_write(16'sh0f0f, 1'b1);
      queue_write(16'shf0f0, 1'b0);
      queue_write(16'sh00ff, 1'b0);
      queue_write(16'shff00, 1'b0);
      queue_write(16'sh8001, 1'b0);
      queue_read(65);
      queue_write(16'sh7ffe, 1'b0);
      queue_read(1);
      queue_read(1);

      // Fill to one short of the threshold. A block start there does not drop,
      // since only 4094 are held. The ring then fills up, and further writes
      // overwrite the oldest samples while the write pointer wraps around.
      drain_next = 1'b1;
      queue_fill(arb_pkg::DEPTH - 2);
      queue_write(16'($urandom), 1'b1);
      queue_write(16'($urandom), 1'b0);
      queue_write(16'($urandom), 1'b0);
      queue_write(16'($urandom), 1'b0);
      queue_write(16'($urandom), 1'b0);
      queue_read(64);

      // With 4095 held, a block start empties the ring first. This stretch runs
      // with no gaps on either side.
      steady_phase = 1'b1;
      queue_fill(arb_pkg::DEPTH - 1);
      queue_write(16'($urandom), 1'b1);
      queue_write(16'($urandom), 1'b0);
      queue_read(64);
      steady_phase = 1'b0;

      // A block start on a completely full ring also empties it.
      queue_fill(arb_pkg::DEPTH);
      queue_write(16'($urandom), 1'b1);
      queue_read(3);
      queue_read(9);

      // Random part. Most of it is write blocks followed by a read; the rest is
      // stray writes and reads, often of an empty ring or with a zero count.
      made = 0;
      while (made < 250) begin
         if ($urandom_range(0, 9) < 8) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 100) : $urandom_range(1, 40);
            for (int k = 0; k < len; k++)
               queue_write(16'($urandom), (k == 0));
            made += len;
         end else if ($urandom_range(0, 1) == 0) begin
            queue_write(16'($urandom), 1'($urandom_range(0, 1)));
            made++;
         end
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 11) == 0)
            drain_next = 1'b1;
         if (pick < 70)
            queue_read($urandom_range(1, 64));
         else if (pick < 85)
            queue_read($urandom_range(65, 127));
         else
            queue_read(0);
         made++;
      end

      while (requests_waiting.size() != 0 || req_valid || samples_due.size() != 0)
         @(posedge clock);
      // Writes give no results, so keep watching afterwards for anything stray.
      repeat (20) @(posedge clock);
      if (error_count == 0 && samples_due.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
